// File: rtl/core/ifs_pkg.sv
package ifs_pkg;

	localparam int CHAR_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int MAP_WORDS = 4;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

	localparam logic [CFG_IDX_W-1:0] CFG_IFS_UNSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_W0    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_W1    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_W2    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_W3    = 3'd4;

	typedef enum logic [1:0] {
		KIND_DATA       = 2'd0,
		KIND_FIELD_END  = 2'd1,
		KIND_STRING_END = 2'd2
	} item_kind_t;

	typedef struct packed {
		logic is_sep;
		logic is_ws;
	} ifs_class_t;

endpackage

// File: rtl/core/ifs_field_splitter_unit.sv
// Field splitter: one string byte in per transaction, one result out per transaction.
// Path: an accepted byte sets pending result flags, which drain into the registered output.
// Throughput: one byte per cycle while out_ready holds and each byte yields at most one
// result; a k-result byte blocks input until its last pops (k up to 3, at string end).
// Reset (arst_n low): split phase to leading skip, default separators, map cleared.
module ifs_field_splitter_unit
	import ifs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CHAR_W-1:0]     char_byte,
	input  logic                  string_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            item_kind,
	output logic [CHAR_W-1:0]     field_byte,
	output logic                  run_last
);

	typedef enum logic [1:0] {
		PH_LEAD      = 2'd0,
		PH_FIELD     = 2'd1,
		PH_AFTER_SEP = 2'd2,
		PH_AFTER_WS  = 2'd3
	} phase_t;

	ifs_class_t  cls;
	phase_t      phase_q, phase_nx;
	logic        data_nx, fe_nx, se_nx;
	logic        data_s1, fe_s1, se_s1;
	logic [CHAR_W-1:0] byte_s1;
	logic        pend, pop, pop_last, acc;
	item_kind_t  pop_kind;
	item_kind_t  kind_q;
	logic [CHAR_W-1:0] byte_q;
	logic        valid_q, last_q;

	ifs_sep_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.char_byte (char_byte),
		.cls       (cls)
	);

	always_comb begin
		phase_nx = phase_q;
		data_nx  = 1'b0;
		fe_nx    = 1'b0;
		se_nx    = 1'b0;
		if (!cls.is_sep) begin
			data_nx  = 1'b1;
			phase_nx = PH_FIELD;
		end else if (cls.is_ws) begin
			if (phase_q == PH_FIELD) begin
				fe_nx    = 1'b1;
				phase_nx = PH_AFTER_WS;
			end
		end else begin
			if (phase_q != PH_AFTER_WS)
				fe_nx = 1'b1;
			phase_nx = PH_AFTER_SEP;
		end
		if (string_end) begin
			if (phase_nx == PH_FIELD)
				fe_nx = 1'b1;
			se_nx    = 1'b1;
			phase_nx = PH_LEAD;
		end
	end

	// pending results drain in order: data, field end, string end
	always_comb begin
		pend = data_s1 || fe_s1 || se_s1;
		pop  = pend && (!valid_q || out_ready);
		if (data_s1) begin
			pop_kind = KIND_DATA;
			pop_last = !fe_s1 && !se_s1;
		end else if (fe_s1) begin
			pop_kind = KIND_FIELD_END;
			pop_last = !se_s1;
		end else begin
			pop_kind = KIND_STRING_END;
			pop_last = 1'b1;
		end
		in_ready = !pend || (pop && pop_last);
		acc      = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			data_s1 <= 1'b0;
			fe_s1   <= 1'b0;
			se_s1   <= 1'b0;
		end else if (acc) begin
			phase_q <= phase_nx;
			data_s1 <= data_nx;
			fe_s1   <= fe_nx;
			se_s1   <= se_nx;
		end else if (pop) begin
			case (pop_kind)
				KIND_DATA:      data_s1 <= 1'b0;
				KIND_FIELD_END: fe_s1   <= 1'b0;
				default:        se_s1   <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			byte_s1 <= char_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= pop_kind;
			byte_q <= (pop_kind == KIND_DATA) ? byte_s1 : '0;
			last_q <= pop_last;
		end
	end

	assign out_valid  = valid_q;
	assign item_kind  = kind_q;
	assign field_byte = byte_q;
	assign run_last   = last_q;

	a_se_phase_lead: assert property (@(posedge clk) disable iff (!arst_n)
		se_s1 |-> phase_q == PH_LEAD)
		else $error("string end pending outside leading skip");

	a_data_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		(data_s1 && !fe_s1) |-> phase_q == PH_FIELD)
		else $error("lone data byte pending outside a field");

	a_multi_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(fe_s1 && se_s1) |-> !in_ready)
		else $error("input taken while two results pending");

	a_se_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q == KIND_STRING_END) |-> last_q)
		else $error("string end not marked last");

	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_q)
		else $error("result register not loaded");

endmodule

// File: rtl/core/ifs_sep_map.sv
module ifs_sep_map
	import ifs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [CHAR_W-1:0]     char_byte,
	output ifs_class_t            cls
);

	logic                                 unset_q;
	logic [MAP_WORDS-1:0][CFG_DATA_W-1:0] map_q;
	logic                                 ws_char;
	logic                                 dflt_sep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unset_q <= 1'b1;
			map_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IFS_UNSET: unset_q  <= cfg_data[0];
				CFG_MAP_W0:    map_q[0] <= cfg_data;
				CFG_MAP_W1:    map_q[1] <= cfg_data;
				CFG_MAP_W2:    map_q[2] <= cfg_data;
				CFG_MAP_W3:    map_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		dflt_sep   = (char_byte == CH_SPACE) || (char_byte == CH_TAB) || (char_byte == CH_NL);
		ws_char    = dflt_sep || (char_byte == CH_CR);
		cls.is_sep = unset_q ? dflt_sep : map_q[char_byte[7:6]][char_byte[5:0]];
		cls.is_ws  = ws_char && cls.is_sep;
	end

endmodule
